FILE: hdl/bpa_pkg.sv
// Shared types, constants and helpers of the buddy page allocator.
package bpa_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int LINK_W     = PAGE_W + 1;
    localparam int TOP_ORDER  = 10;
    localparam int NUM_ORDERS = TOP_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int SUM_W      = LINK_W + 1;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(NUM_PAGES);
    localparam logic [LINK_W-1:0] MAX_PAGES = LINK_W'(NUM_PAGES);
    localparam logic [ORD_W-1:0]  TOP_ORD   = ORD_W'(TOP_ORDER);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_RESERVE = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_TOP,
        S_INIT_LOW,
        S_INIT_NEXT,
        S_AL_SRCH,
        S_AL_TAKE,
        S_AL_SPLIT,
        S_FR_CHK,
        S_FR_LOOP,
        S_FR_BUD,
        S_FR_MERGE,
        S_FR_FIN,
        S_RV_ORD,
        S_RV_CHK,
        S_RV_NXT,
        S_RV_ACT,
        S_RV_HI,
        S_RV_RESUME,
        S_RV_STEP,
        S_APP1,
        S_APP2,
        S_REM_RD,
        S_REM_1,
        S_REM_2,
        S_DONE
    } ctrl_state_t;

    // Page store: low lane is the order, high lane the taken mark.
    typedef struct packed {
        logic              we_lo;
        logic              we_hi;
        logic [PAGE_W-1:0] waddr;
        logic [ORD_W:0]    wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } page_req_t;

    // Link store: low lane is the next link, high lane the previous link.
    typedef struct packed {
        logic                we_lo;
        logic                we_hi;
        logic [PAGE_W-1:0]   waddr;
        logic [2*LINK_W-1:0] wdata;
        logic                re;
        logic [PAGE_W-1:0]   raddr;
    } link_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] page;
        logic [ORD_W-1:0]  order;
    } res_t;

    function automatic logic [SUM_W-1:0] block_size(input logic [ORD_W-1:0] ord);
        block_size = SUM_W'(1) << ord;
    endfunction

    function automatic logic [PAGE_W-1:0] buddy_of(input logic [PAGE_W-1:0] pg,
                                                   input logic [ORD_W-1:0] ord);
        buddy_of = pg ^ (PAGE_W'(1) << ord);
    endfunction

endpackage

FILE: hdl/bpa_ram.sv
// Synchronous RAM with two write lanes and a registered read port.
module bpa_ram #(
    parameter int ADDR_W = 12,
    parameter int LO_W   = 4,
    parameter int HI_W   = 1
) (
    input  logic                   aclk,
    input  logic                   we_lo,
    input  logic                   we_hi,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [LO_W+HI_W-1:0]   wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [LO_W+HI_W-1:0]   rdata
);

    logic [LO_W+HI_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we_lo) begin
            mem[waddr][LO_W-1:0] <= wdata[LO_W-1:0];
        end
        if (we_hi) begin
            mem[waddr][LO_W+HI_W-1:LO_W] <= wdata[LO_W+HI_W-1:LO_W];
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bpa_ctrl.sv
// Sequencer: runs init, allocate, free and reserve over the page and link stores.
module bpa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bpa_pkg::cmd_t                 in_cmd,
    input  logic [bpa_pkg::ORD_W-1:0]     in_req,
    input  logic [bpa_pkg::PAGE_W-1:0]    in_pidx,
    input  logic [bpa_pkg::LINK_W-1:0]    in_cnt,
    input  logic [bpa_pkg::LINK_W-1:0]    managed,
    output bpa_pkg::page_req_t            page_req,
    input  logic [bpa_pkg::ORD_W:0]       page_rdata,
    output bpa_pkg::link_req_t            link_req,
    input  logic [2*bpa_pkg::LINK_W-1:0]  link_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bpa_pkg::res_t                 res
);
    import bpa_pkg::*;

    ctrl_state_t state_reg, state_next, ret_reg, ret_next;

    logic [LINK_W-1:0] head_reg [NUM_ORDERS];
    logic [LINK_W-1:0] head_next [NUM_ORDERS];
    logic [LINK_W-1:0] tail_reg [NUM_ORDERS];
    logic [LINK_W-1:0] tail_next [NUM_ORDERS];
    logic [LINK_W-1:0] live_reg, live_next;
    logic [PAGE_W-1:0] clr_reg, clr_next;
    logic              clr_init_reg, clr_init_next;

    logic [ORD_W-1:0]  req_reg, req_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic [LINK_W-1:0] end_reg, end_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [PAGE_W-1:0] pg_reg, pg_next;
    logic [LINK_W-1:0] seed_reg, seed_next;
    logic [LINK_W-1:0] guard_reg, guard_next;
    logic [LINK_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic [ORD_W-1:0]  sub_ord_reg, sub_ord_next;
    logic [PAGE_W-1:0] sub_page_reg, sub_page_next;
    logic [LINK_W-1:0] rem_n_reg, rem_n_next;
    logic [LINK_W-1:0] rem_pr_reg, rem_pr_next;
    res_t              res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            clr_init_reg <= 1'b0;
            live_reg     <= '0;
            for (int i = 0; i < NUM_ORDERS; i++) begin
                head_reg[i] <= NIL_LINK;
                tail_reg[i] <= NIL_LINK;
            end
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_init_reg <= clr_init_next;
            live_reg     <= live_next;
            for (int i = 0; i < NUM_ORDERS; i++) begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg      <= ret_next;
        req_reg      <= req_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        ord_reg      <= ord_next;
        pg_reg       <= pg_next;
        seed_reg     <= seed_next;
        guard_reg    <= guard_next;
        p_reg        <= p_next;
        nx_reg       <= nx_next;
        sub_ord_reg  <= sub_ord_next;
        sub_page_reg <= sub_page_next;
        rem_n_reg    <= rem_n_next;
        rem_pr_reg   <= rem_pr_next;
        res_reg      <= res_next;
    end

    always_comb begin
        logic [ORD_W-1:0]  lidx;
        logic [LINK_W-1:0] hsel;
        logic [LINK_W-1:0] tsel;
        logic              hit;
        logic [ORD_W-1:0]  fi;
        logic [ORD_W-1:0]  o1;
        logic [PAGE_W-1:0] bud;
        logic [SUM_W-1:0]  bend;
        logic [SUM_W-1:0]  sum;
        logic              take;
        logic [LINK_W-1:0] rd_n;
        logic [LINK_W-1:0] rd_pr;

        state_next    = state_reg;
        ret_next      = ret_reg;
        live_next     = live_reg;
        clr_next      = clr_reg;
        clr_init_next = clr_init_reg;
        req_next      = req_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        ord_next      = ord_reg;
        pg_next       = pg_reg;
        seed_next     = seed_reg;
        guard_next    = guard_reg;
        p_next        = p_reg;
        nx_next       = nx_reg;
        sub_ord_next  = sub_ord_reg;
        sub_page_next = sub_page_reg;
        rem_n_next    = rem_n_reg;
        rem_pr_next   = rem_pr_reg;
        res_next      = res_reg;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        page_req  = '0;
        link_req  = '0;
        in_ready  = 1'b0;
        res_valid = 1'b0;

        lidx = (state_reg inside {S_APP1, S_APP2, S_REM_RD, S_REM_1, S_REM_2}) ?
               sub_ord_reg : ord_reg;
        hsel  = head_reg[lidx];
        tsel  = tail_reg[lidx];
        o1    = ord_reg - ORD_W'(1);
        rd_n  = link_rdata[LINK_W-1:0];
        rd_pr = link_rdata[2*LINK_W-1:LINK_W];
        bend  = SUM_W'(p_reg) + block_size(ord_reg);
        take  = ((SUM_W'(p_reg) >= SUM_W'(start_reg)) && (bend <= SUM_W'(end_reg))) ||
                (ord_reg == '0);
        sum   = SUM_W'(in_pidx) + SUM_W'(in_cnt);
        bud   = buddy_of(pg_reg, ord_reg);

        // Smallest non-empty list at or above the requested order.
        hit = 1'b0;
        fi  = '0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (!hit && (ORD_W'(i) >= req_reg) && !head_reg[i][LINK_W-1]) begin
                hit = 1'b1;
                fi  = ORD_W'(i);
            end
        end

        case (state_reg)
            S_CLEAR: begin
                page_req.we_lo = 1'b1;
                page_req.we_hi = 1'b1;
                page_req.waddr = clr_reg;
                page_req.wdata = '0;
                clr_next = clr_reg + PAGE_W'(1);
                if (clr_reg == PAGE_W'(NUM_PAGES - 1)) begin
                    seed_next  = '0;
                    state_next = clr_init_reg ? S_INIT_TOP : S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = in_req;
                    start_next = in_pidx;
                    pg_next    = in_pidx;
                    res_next   = '{status: ST_IGNORED, page: '0, order: '0};
                    case (in_cmd)
                        CMD_INIT: begin
                            for (int i = 0; i < NUM_ORDERS; i++) begin
                                head_next[i] = NIL_LINK;
                                tail_next[i] = NIL_LINK;
                            end
                            live_next     = (managed > MAX_PAGES) ? MAX_PAGES : managed;
                            clr_next      = '0;
                            clr_init_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        CMD_ALLOC: begin
                            state_next = (in_req > TOP_ORD) ? S_DONE : S_AL_SRCH;
                        end
                        CMD_FREE: begin
                            if (LINK_W'(in_pidx) >= live_reg) begin
                                state_next = S_DONE;
                            end else begin
                                page_req.re    = 1'b1;
                                page_req.raddr = in_pidx;
                                state_next     = S_FR_CHK;
                            end
                        end
                        CMD_RESERVE: begin
                            if (in_cnt == '0 || LINK_W'(in_pidx) >= live_reg) begin
                                state_next = S_DONE;
                            end else begin
                                end_next   = (sum > SUM_W'(live_reg)) ? live_reg :
                                             sum[LINK_W-1:0];
                                ord_next   = TOP_ORD;
                                state_next = S_RV_ORD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INIT_TOP: begin
                if (SUM_W'(seed_reg) + block_size(TOP_ORD) <= SUM_W'(live_reg)) begin
                    page_req.we_lo = 1'b1;
                    page_req.we_hi = 1'b1;
                    page_req.waddr = seed_reg[PAGE_W-1:0];
                    page_req.wdata = {1'b0, TOP_ORD};
                    seed_next      = seed_reg + LINK_W'(block_size(TOP_ORD));
                    sub_ord_next   = TOP_ORD;
                    sub_page_next  = seed_reg[PAGE_W-1:0];
                    ret_next       = S_INIT_TOP;
                    state_next     = S_APP1;
                end else begin
                    ord_next   = TOP_ORD - ORD_W'(1);
                    state_next = S_INIT_LOW;
                end
            end
            S_INIT_LOW: begin
                state_next = S_INIT_NEXT;
                if (SUM_W'(seed_reg) + block_size(ord_reg) <= SUM_W'(live_reg)) begin
                    page_req.we_lo = 1'b1;
                    page_req.we_hi = 1'b1;
                    page_req.waddr = seed_reg[PAGE_W-1:0];
                    page_req.wdata = {1'b0, ord_reg};
                    seed_next      = seed_reg + LINK_W'(block_size(ord_reg));
                    sub_ord_next   = ord_reg;
                    sub_page_next  = seed_reg[PAGE_W-1:0];
                    ret_next       = S_INIT_NEXT;
                    state_next     = S_APP1;
                end
            end
            S_INIT_NEXT: begin
                if (ord_reg == '0) begin
                    res_next   = '{status: ST_OK, page: '0, order: '0};
                    state_next = S_DONE;
                end else begin
                    ord_next   = o1;
                    state_next = S_INIT_LOW;
                end
            end
            S_AL_SRCH: begin
                if (!hit) begin
                    res_next   = '{status: ST_NOFIT, page: '0, order: '0};
                    state_next = S_DONE;
                end else begin
                    ord_next   = fi;
                    state_next = S_AL_TAKE;
                end
            end
            S_AL_TAKE: begin
                pg_next       = hsel[PAGE_W-1:0];
                sub_ord_next  = ord_reg;
                sub_page_next = hsel[PAGE_W-1:0];
                ret_next      = S_AL_SPLIT;
                state_next    = S_REM_RD;
            end
            S_AL_SPLIT: begin
                page_req.we_lo = 1'b1;
                page_req.we_hi = 1'b1;
                if (ord_reg > req_reg) begin
                    page_req.waddr = buddy_of(pg_reg, o1);
                    page_req.wdata = {1'b0, o1};
                    ord_next       = o1;
                    sub_ord_next   = o1;
                    sub_page_next  = buddy_of(pg_reg, o1);
                    ret_next       = S_AL_SPLIT;
                    state_next     = S_APP1;
                end else begin
                    page_req.waddr = pg_reg;
                    page_req.wdata = {1'b1, req_reg};
                    res_next       = '{status: ST_OK, page: pg_reg, order: req_reg};
                    state_next     = S_DONE;
                end
            end
            S_FR_CHK: begin
                if (!page_rdata[ORD_W]) begin
                    state_next = S_DONE;
                end else begin
                    ord_next       = page_rdata[ORD_W-1:0];
                    page_req.we_hi = 1'b1;
                    page_req.waddr = pg_reg;
                    page_req.wdata = '0;
                    state_next     = S_FR_LOOP;
                end
            end
            S_FR_LOOP: begin
                if (ord_reg < TOP_ORD && LINK_W'(bud) < live_reg) begin
                    page_req.re    = 1'b1;
                    page_req.raddr = bud;
                    state_next     = S_FR_BUD;
                end else begin
                    state_next = S_FR_FIN;
                end
            end
            S_FR_BUD: begin
                if (page_rdata[ORD_W] || page_rdata[ORD_W-1:0] != ord_reg) begin
                    state_next = S_FR_FIN;
                end else begin
                    sub_ord_next  = ord_reg;
                    sub_page_next = bud;
                    ret_next      = S_FR_MERGE;
                    state_next    = S_REM_RD;
                end
            end
            S_FR_MERGE: begin
                if (bud < pg_reg) begin
                    pg_next = bud;
                end
                ord_next   = ord_reg + ORD_W'(1);
                state_next = S_FR_LOOP;
            end
            S_FR_FIN: begin
                page_req.we_lo = 1'b1;
                page_req.we_hi = 1'b1;
                page_req.waddr = pg_reg;
                page_req.wdata = {1'b0, ord_reg};
                res_next       = '{status: ST_OK, page: pg_reg, order: ord_reg};
                sub_ord_next   = ord_reg;
                sub_page_next  = pg_reg;
                ret_next       = S_DONE;
                state_next     = S_APP1;
            end
            S_RV_ORD: begin
                p_next     = hsel;
                guard_next = '0;
                state_next = S_RV_CHK;
            end
            S_RV_CHK: begin
                if (p_reg[LINK_W-1] || guard_reg == MAX_PAGES) begin
                    state_next = S_RV_STEP;
                end else begin
                    guard_next = guard_reg + LINK_W'(1);
                    if (!(bend <= SUM_W'(start_reg) || p_reg >= end_reg)) begin
                        sub_ord_next  = ord_reg;
                        sub_page_next = p_reg[PAGE_W-1:0];
                        ret_next      = S_RV_ACT;
                        state_next    = S_REM_RD;
                    end else begin
                        link_req.re    = 1'b1;
                        link_req.raddr = p_reg[PAGE_W-1:0];
                        state_next     = S_RV_NXT;
                    end
                end
            end
            S_RV_NXT: begin
                p_next     = rd_n;
                state_next = S_RV_CHK;
            end
            S_RV_ACT: begin
                nx_next = rem_n_reg;
                if (take) begin
                    page_req.we_hi = 1'b1;
                    page_req.waddr = p_reg[PAGE_W-1:0];
                    page_req.wdata = {1'b1, ORD_W'(0)};
                    p_next         = rem_n_reg;
                    state_next     = S_RV_CHK;
                end else begin
                    page_req.we_lo = 1'b1;
                    page_req.we_hi = 1'b1;
                    page_req.waddr = p_reg[PAGE_W-1:0];
                    page_req.wdata = {1'b0, o1};
                    sub_ord_next   = o1;
                    sub_page_next  = p_reg[PAGE_W-1:0];
                    ret_next       = S_RV_HI;
                    state_next     = S_APP1;
                end
            end
            S_RV_HI: begin
                page_req.we_lo = 1'b1;
                page_req.we_hi = 1'b1;
                page_req.waddr = buddy_of(p_reg[PAGE_W-1:0], o1);
                page_req.wdata = {1'b0, o1};
                sub_ord_next   = o1;
                sub_page_next  = buddy_of(p_reg[PAGE_W-1:0], o1);
                ret_next       = S_RV_RESUME;
                state_next     = S_APP1;
            end
            S_RV_RESUME: begin
                p_next     = nx_reg;
                state_next = S_RV_CHK;
            end
            S_RV_STEP: begin
                if (ord_reg == '0) begin
                    res_next   = '{status: ST_OK, page: '0, order: '0};
                    state_next = S_DONE;
                end else begin
                    ord_next   = o1;
                    state_next = S_RV_ORD;
                end
            end
            S_APP1: begin
                link_req.we_lo = 1'b1;
                link_req.we_hi = 1'b1;
                link_req.waddr = sub_page_reg;
                link_req.wdata = {tsel, NIL_LINK};
                tail_next[sub_ord_reg] = LINK_W'(sub_page_reg);
                rem_pr_next = tsel;
                if (tsel[LINK_W-1]) begin
                    head_next[sub_ord_reg] = LINK_W'(sub_page_reg);
                    state_next = ret_reg;
                end else begin
                    state_next = S_APP2;
                end
            end
            S_APP2: begin
                link_req.we_lo = 1'b1;
                link_req.waddr = rem_pr_reg[PAGE_W-1:0];
                link_req.wdata = {NIL_LINK, LINK_W'(sub_page_reg)};
                state_next     = ret_reg;
            end
            S_REM_RD: begin
                link_req.re    = 1'b1;
                link_req.raddr = sub_page_reg;
                state_next     = S_REM_1;
            end
            S_REM_1: begin
                rem_n_next  = rd_n;
                rem_pr_next = rd_pr;
                if (rd_pr[LINK_W-1]) begin
                    head_next[sub_ord_reg] = rd_n;
                end else begin
                    link_req.we_lo = 1'b1;
                    link_req.waddr = rd_pr[PAGE_W-1:0];
                    link_req.wdata = {NIL_LINK, rd_n};
                end
                state_next = S_REM_2;
            end
            S_REM_2: begin
                if (rem_n_reg[LINK_W-1]) begin
                    tail_next[sub_ord_reg] = rem_pr_reg;
                end else begin
                    link_req.we_hi = 1'b1;
                    link_req.waddr = rem_n_reg[PAGE_W-1:0];
                    link_req.wdata = {rem_pr_reg, NIL_LINK};
                end
                state_next = ret_reg;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res = res_reg;

endmodule

FILE: hdl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: stream ports, config register, stores.
//
// Usage:
//   One command beat enters on the s_ channel; exactly one result beat leaves
//   on the m_ channel for each. Commands are init, allocate, free and reserve.
//   Commands run one at a time: s_tready is high only while the sequencer is
//   idle. The result sits in an output register, so the next command may be
//   taken while a result still waits for m_tready.
//   Steps per command (the sequencer makes at most one store access per cycle):
//     allocate: takes the head of the smallest fitting list, then splits
//               off one buddy per order down to the requested order
//     free:     clears the taken mark, then merges with one buddy per order
//     reserve:  walks each free list from the top order down, taking or splitting overlapping blocks
//     init:     clears all 4096 pages, then seeds blocks from the top order down
//   The result passes through the output register on its way to m_tvalid.
//   Reset: a clearing pass zeroes all 4096 pages of the page store; s_tready
//   stays low during it. managed_pages resets to 4096 and takes effect at the
//   next init. A stalled receiver holds the result and blocks the sequencer
//   only once a second result is ready.
module buddy_page_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // req_order[3:0], page_index[15:4], page_count[28:16]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // block_page[11:0], block_order[15:12]
    output logic [1:0]  m_tuser,    // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data // managed_pages
);
    import bpa_pkg::*;

    logic [LINK_W-1:0]   managed_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    page_req_t           page_req;
    link_req_t           link_req;
    logic [ORD_W:0]      page_rdata;
    logic [2*LINK_W-1:0] link_rdata;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    // Hold the page count; init samples it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            managed_reg <= MAX_PAGES;
        end else if (cfg_wr_en) begin
            managed_reg <= cfg_wr_data;
        end
    end

    // Output register: load a finished result, drop it once the beat moves.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {out_res_reg.order, out_res_reg.page};

    bpa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser)),
        .in_req     (s_tdata[3:0]),
        .in_pidx    (s_tdata[15:4]),
        .in_cnt     (s_tdata[28:16]),
        .managed    (managed_reg),
        .page_req   (page_req),
        .page_rdata (page_rdata),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Order and taken mark of each page.
    bpa_ram #(
        .ADDR_W (PAGE_W),
        .LO_W   (ORD_W),
        .HI_W   (1)
    ) u_page_ram (
        .aclk   (aclk),
        .we_lo  (page_req.we_lo),
        .we_hi  (page_req.we_hi),
        .waddr  (page_req.waddr),
        .wdata  (page_req.wdata),
        .re     (page_req.re),
        .raddr  (page_req.raddr),
        .rdata  (page_rdata)
    );

    // Free-list next and previous links of each page.
    bpa_ram #(
        .ADDR_W (PAGE_W),
        .LO_W   (LINK_W),
        .HI_W   (LINK_W)
    ) u_link_ram (
        .aclk   (aclk),
        .we_lo  (link_req.we_lo),
        .we_hi  (link_req.we_hi),
        .waddr  (link_req.waddr),
        .wdata  (link_req.wdata),
        .re     (link_req.re),
        .raddr  (link_req.raddr),
        .rdata  (link_rdata)
    );

endmodule

FILE: hdl/bpa_chk.sv
// Port checker for the buddy page allocator, bound to the top level.
module bpa_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import bpa_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // Block fields are zero unless the status is ok.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero block fields on failed command");

    // Reset starts the clearing pass, so no beat is taken right after it.
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

    // One command at a time: busy after each accepted beat.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

    // Status is a defined code and the order stays in range.
    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOFIT || m_tuser == ST_IGNORED)
                     && m_tdata[15:12] <= TOP_ORD)
        else $error("bad status or order on result");

endmodule

bind buddy_page_allocator_top bpa_chk u_bpa_chk (.*);

FILE: test/buddy_page_allocator_top_tb.sv
// Testbench for the buddy page allocator: random command streams checked against a predictor.
`timescale 1ns / 100ps

import bpa_pkg::*;

// Scoreboard: holds the allocator state mirror and the queue of pending results.
class alloc_scoreboard;
    logic [ORD_W-1:0] blk_order [NUM_PAGES];
    bit               blk_taken [NUM_PAGES];
    int               nxt_link  [NUM_PAGES];
    int               prv_link  [NUM_PAGES];
    int               head_of   [NUM_ORDERS];
    int               tail_of   [NUM_ORDERS];
    int               pages_set;
    int               pages_live;
    res_t             pending [$];
    int               errors;

    function new();
        pages_set  = NUM_PAGES;
        pages_live = 0;
        errors     = 0;
        foreach (blk_order[i]) begin
            blk_order[i] = '0;
            blk_taken[i] = 0;
        end
        foreach (head_of[o]) begin
            head_of[o] = NUM_PAGES;
            tail_of[o] = NUM_PAGES;
        end
    endfunction

    function void list_push(int o, int p);
        int t;
        t = tail_of[o];
        nxt_link[p] = NUM_PAGES;
        prv_link[p] = t;
        if (t >= NUM_PAGES) head_of[o] = p;
        else nxt_link[t] = p;
        tail_of[o] = p;
    endfunction

    function void list_drop(int o, int p);
        int n;
        int pr;
        n  = nxt_link[p];
        pr = prv_link[p];
        if (pr >= NUM_PAGES) head_of[o] = n;
        else nxt_link[pr] = n;
        if (n >= NUM_PAGES) tail_of[o] = pr;
        else prv_link[n] = pr;
    endfunction

    function void seed_lists();
        int s;
        s = 0;
        foreach (blk_order[i]) begin
            blk_order[i] = '0;
            blk_taken[i] = 0;
        end
        foreach (head_of[o]) begin
            head_of[o] = NUM_PAGES;
            tail_of[o] = NUM_PAGES;
        end
        pages_live = (pages_set > NUM_PAGES) ? NUM_PAGES : pages_set;
        while (s + (1 << TOP_ORDER) <= pages_live) begin
            blk_order[s] = TOP_ORD;
            list_push(TOP_ORDER, s);
            s += 1 << TOP_ORDER;
        end
        for (int o = TOP_ORDER - 1; o >= 0; o--) begin
            if (s + (1 << o) <= pages_live) begin
                blk_order[s] = ORD_W'(o);
                list_push(o, s);
                s += 1 << o;
            end
        end
    endfunction

    function void carve_range(int first, int last);
        int p;
        int nx;
        int bend;
        int hi;
        int guard;
        for (int o = TOP_ORDER; o >= 0; o--) begin
            p = head_of[o];
            guard = 0;
            while (p < NUM_PAGES && guard < NUM_PAGES) begin
                guard++;
                nx = nxt_link[p];
                bend = p + (1 << o);
                if (!(bend <= first || p >= last)) begin
                    list_drop(o, p);
                    if ((p >= first && bend <= last) || o == 0) begin
                        blk_taken[p] = 1;
                    end else begin
                        hi = p ^ (1 << (o - 1));
                        blk_order[p] = ORD_W'(o - 1);
                        blk_taken[p] = 0;
                        list_push(o - 1, p);
                        blk_order[hi] = ORD_W'(o - 1);
                        blk_taken[hi] = 0;
                        list_push(o - 1, hi);
                    end
                end
                p = nx;
            end
        end
    endfunction

    // Note an accepted command beat: update the mirror, queue the result.
    function res_t note(cmd_t c, int req, int idx, int cnt);
        res_t r;
        int i;
        int pg;
        int bud;
        int o;
        int last;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_INIT: begin
                seed_lists();
            end
            CMD_ALLOC: begin
                if (req > TOP_ORDER) begin
                    r.status = ST_IGNORED;
                end else begin
                    i = req;
                    while (i <= TOP_ORDER && head_of[i] >= NUM_PAGES) i++;
                    if (i > TOP_ORDER) begin
                        r.status = ST_NOFIT;
                    end else begin
                        pg = head_of[i];
                        list_drop(i, pg);
                        while (i > req) begin
                            i--;
                            bud = pg ^ (1 << i);
                            blk_order[bud] = ORD_W'(i);
                            blk_taken[bud] = 0;
                            list_push(i, bud);
                        end
                        blk_order[pg] = ORD_W'(req);
                        blk_taken[pg] = 1;
                        r.page  = PAGE_W'(pg);
                        r.order = ORD_W'(req);
                    end
                end
            end
            CMD_FREE: begin
                if (idx >= pages_live || !blk_taken[idx]) begin
                    r.status = ST_IGNORED;
                end else begin
                    pg = idx;
                    o = int'(blk_order[pg]);
                    blk_taken[pg] = 0;
                    while (o < TOP_ORDER) begin
                        bud = pg ^ (1 << o);
                        if (bud >= pages_live || blk_taken[bud] ||
                            int'(blk_order[bud]) != o) break;
                        list_drop(o, bud);
                        if (bud < pg) pg = bud;
                        o++;
                    end
                    blk_order[pg] = ORD_W'(o);
                    list_push(o, pg);
                    r.page  = PAGE_W'(pg);
                    r.order = ORD_W'(o);
                end
            end
            default: begin
                if (cnt == 0 || idx >= pages_live) begin
                    r.status = ST_IGNORED;
                end else begin
                    last = idx + cnt;
                    if (last > pages_live) last = pages_live;
                    carve_range(idx, last);
                end
            end
        endcase
        pending.push_back(r);
        return r;
    endfunction

    // Compare a result beat with the oldest pending result.
    function void check(res_t got);
        res_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result status=%0d page=%0d order=%0d",
                     $time, got.status, got.page, got.order);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.page !== want.page) begin
            $display("%0t: block_page expected %0d actual %0d", $time, want.page, got.page);
            errors++;
        end
        if (got.order !== want.order) begin
            $display("%0t: block_order expected %0d actual %0d", $time, want.order, got.order);
            errors++;
        end
    endfunction
endclass

module buddy_page_allocator_top_tb;

    localparam int IDLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = '0;

    alloc_scoreboard sb = new();
    int  held [$];          // heads of blocks handed out by allocate
    bit  gaps_on = 1'b1;
    int  stall_left = 0;
    int  idle_cycles = 0;

    buddy_page_allocator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: check every beat, stall in short random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check('{status: m_tuser, page: m_tdata[11:0], order: m_tdata[15:12]});
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("buddy_page_allocator_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one command beat, hold it until accepted, then maybe idle a little.
    task automatic send(cmd_t c, int req, int idx, int cnt);
        res_t r;
        s_tuser  <= c;
        s_tdata  <= {3'b0, cnt[12:0], idx[11:0], req[3:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = sb.note(c, int'(req[3:0]), int'(idx[11:0]), int'(cnt[12:0]));
        if (c == CMD_INIT) held.delete();
        if (c == CMD_ALLOC && r.status == ST_OK) held.push_back(int'(r.page));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Drop valid, wait out every pending result plus a margin.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_pages(int n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[12:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.pages_set = n;
    endtask

    // One random command, weighted toward well-formed alloc/free traffic.
    task automatic random_cmd();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            send(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 4), 0, 0);
        end else if (pick < 80 && held.size() > 0) begin
            k = $urandom_range(0, held.size() - 1);
            send(CMD_FREE, 0, held[k], 0);
            held.delete(k);
        end else if (pick < 88) begin
            send(CMD_FREE, $urandom_range(0, 15), $urandom_range(0, 4095),
                 $urandom_range(0, 8191));
        end else if (pick < 99) begin
            send(CMD_RESERVE, $urandom_range(0, 15), $urandom_range(0, 4095),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, 40));
        end else begin
            send(CMD_INIT, $urandom_range(0, 15), $urandom_range(0, 4095),
                 $urandom_range(0, 8191));
        end
    endtask

    initial begin
        int sizes [6] = '{4096, 1, 1000, 8191, 2049, 0};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Before any init: nothing is live.
        send(CMD_ALLOC, 0, 0, 0);
        send(CMD_FREE, 0, 0, 0);
        send(CMD_RESERVE, 0, 0, 5);
        send(CMD_ALLOC, 15, 4095, 8191);
        send(CMD_INIT, 0, 0, 0);
        send(CMD_ALLOC, 0, 0, 0);
        send(CMD_ALLOC, TOP_ORDER, 0, 0);
        send(CMD_ALLOC, 11, 0, 0);
        send(CMD_FREE, 0, 1, 0);        // free a split-off page that is not taken
        send(CMD_FREE, 0, 0, 0);        // free the order-0 block, merges back up
        send(CMD_FREE, 0, 0, 0);        // second free of the same block
        send(CMD_RESERVE, 0, 100, 0);   // empty reserve
        send(CMD_RESERVE, 0, 4095, 4096); // end clipped to managed pages
        send(CMD_RESERVE, 0, 3, 700);   // unaligned range splits blocks
        send(CMD_FREE, 0, 4095, 0);
        send(CMD_ALLOC, TOP_ORDER, 0, 0);
        send(CMD_ALLOC, TOP_ORDER, 0, 0);
        send(CMD_ALLOC, TOP_ORDER, 0, 0);
        send(CMD_ALLOC, TOP_ORDER, 0, 0); // runs dry
        drain();
        write_pages(700);
        send(CMD_ALLOC, 0, 0, 0);       // new size not yet in effect
        send(CMD_FREE, 0, 4000, 0);
        drain();

        foreach (sizes[ph]) begin
            if (ph == 5) gaps_on = 1'b0;
            write_pages(sizes[ph]);
            send(CMD_INIT, 0, 0, 0);
            repeat (265) random_cmd();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("buddy_page_allocator_top_tb OK");
        end else begin
            $display("buddy_page_allocator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
